@@ rtl/core/ssdp_pkg.sv @@
// ssdp_pkg: shared types, constants and lookup functions of the SSDP header parser.
`timescale 1ns / 1ps
package ssdp_pkg;

  localparam int NumKeys    = 9;
  localparam int StatusLen  = 15;
  localparam int QueueDepth = 4;
  localparam int QueuePtrW  = $clog2(QueueDepth);

  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_NUL   = 8'h00;

  localparam logic [1:0] KIND_VALUE = 2'd0;
  localparam logic [1:0] KIND_END   = 2'd1;
  localparam logic [1:0] KIND_CLASS = 2'd2;

  localparam logic [1:0] CLS_NONE    = 2'd0;
  localparam logic [1:0] CLS_NO_HTTP = 2'd1;
  localparam logic [1:0] CLS_UPNP    = 2'd2;

  // bundle mask bits, in emit order
  localparam int BM_CR    = 0;
  localparam int BM_BYTE  = 1;
  localparam int BM_END   = 2;
  localparam int BM_CLASS = 3;

  typedef enum logic [1:0] {
    PH_SEEK = 2'd0,
    PH_HDR  = 2'd1,
    PH_DONE = 2'd2
  } phase_t;

  typedef enum logic [1:0] {
    MD_KEY  = 2'd0,
    MD_VAL  = 2'd1,
    MD_SKIP = 2'd2
  } mode_t;

  typedef struct packed {
    logic [7:0] payload_byte;
    logic       packet_end;
  } in_item_t;

  typedef struct packed {
    logic [1:0] result_kind;
    logic [3:0] header_key;
    logic [7:0] value_byte;
    logic [1:0] classification;
    logic       run_last;
  } out_item_t;

  // all results caused by one input item
  typedef struct packed {
    logic [3:0] mask;
    logic [3:0] key;
    logic [7:0] vbyte;
    logic [1:0] cls;
  } bundle_t;

  function automatic logic [3:0] key_len(input logic [3:0] k);
    logic [3:0] n;
    case (k)
      4'd0:    n = 4'd6;
      4'd1:    n = 4'd8;
      4'd2:    n = 4'd3;
      4'd3:    n = 4'd3;
      4'd4:    n = 4'd2;
      4'd5:    n = 4'd5;
      4'd6:    n = 4'd12;
      4'd7:    n = 4'd4;
      4'd8:    n = 4'd13;
      default: n = 4'd0;
    endcase
    return n;
  endfunction

  // lower-case key character at position p, zero past the end of the name
  function automatic logic [7:0] key_char(input logic [3:0] k, input logic [3:0] p);
    logic [103:0] s;
    logic [3:0]   n;
    logic [3:0]   idx;
    logic [7:0]   c;
    n = key_len(k);
    case (k)
      4'd0:    s = 104'("server");
      4'd1:    s = 104'("location");
      4'd2:    s = 104'("usn");
      4'd3:    s = 104'("ext");
      4'd4:    s = 104'("st");
      4'd5:    s = 104'("agent");
      4'd6:    s = 104'("x-user-agent");
      4'd7:    s = 104'("date");
      4'd8:    s = 104'("cache-control");
      default: s = '0;
    endcase
    idx = n - 4'd1 - p;
    if (p < n) begin
      c = s[{idx, 3'b000} +: 8];
    end else begin
      c = 8'h00;
    end
    return c;
  endfunction

  // status line character at position p, zero past the end
  function automatic logic [7:0] status_char(input logic [3:0] p);
    logic [119:0] s;
    logic [3:0]   idx;
    logic [7:0]   c;
    s   = "HTTP/1.1 200 OK";
    idx = 4'(StatusLen - 1) - p;
    if (p < 4'(StatusLen)) begin
      c = s[{idx, 3'b000} +: 8];
    end else begin
      c = 8'h00;
    end
    return c;
  endfunction

endpackage

@@ rtl/core/ssdp_front.sv @@
// ssdp_front: per-byte line parser; turns each accepted byte into a result bundle.
`timescale 1ns / 1ps
module ssdp_front
  import ssdp_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     take,
  input  in_item_t item,
  output logic     bundle_push,
  output bundle_t  bundle
);

  phase_t     phase_r, phase_nxt;
  mode_t      mode_r, mode_nxt;
  logic [3:0] pos_r, pos_nxt;
  logic [8:0] cand_r, cand_nxt;
  logic [3:0] akey_r, akey_nxt;
  logic       vstart_r, vstart_nxt;
  logic       hcr_r, hcr_nxt;
  logic       smis_r, smis_nxt;
  logic [1:0] pcls_r, pcls_nxt;

  logic [7:0] b;
  logic [7:0] lc;
  logic       term;
  logic       do_end;

  assign b = item.payload_byte;

  always_comb begin
    phase_nxt  = phase_r;
    mode_nxt   = mode_r;
    pos_nxt    = pos_r;
    cand_nxt   = cand_r;
    akey_nxt   = akey_r;
    vstart_nxt = vstart_r;
    hcr_nxt    = hcr_r;
    smis_nxt   = smis_r;
    pcls_nxt   = pcls_r;
    bundle     = '0;
    lc         = (b inside {[8'h41:8'h5A]}) ? b + 8'd32 : b;
    term       = (b == CH_NUL) || (b == CH_LF);

    // ordinary byte
    if (phase_r != PH_DONE && !term) begin
      if (phase_r == PH_SEEK) begin
        if (hcr_nxt) begin
          if (status_char(pos_nxt) != CH_CR) smis_nxt = 1'b1;
          if (pos_nxt != 4'hF) pos_nxt = pos_nxt + 4'd1;
          hcr_nxt = 1'b0;
        end
        if (b == CH_CR) begin
          hcr_nxt = 1'b1;
        end else begin
          if (status_char(pos_nxt) != b) smis_nxt = 1'b1;
          if (pos_nxt != 4'hF) pos_nxt = pos_nxt + 4'd1;
        end
      end else if (mode_r == MD_KEY) begin
        if (b == CH_COLON) begin
          mode_nxt = MD_SKIP;
          for (int k = 0; k < NumKeys; k++) begin
            if (cand_r[k] && key_len(4'(k)) == pos_r) begin
              akey_nxt   = 4'(k);
              mode_nxt   = MD_VAL;
              vstart_nxt = 1'b0;
            end
          end
        end else begin
          for (int k = 0; k < NumKeys; k++) begin
            if (key_char(4'(k), pos_r) != lc) cand_nxt[k] = 1'b0;
          end
          if (pos_r != 4'hF) pos_nxt = pos_r + 4'd1;
        end
      end else if (mode_r == MD_VAL) begin
        if (hcr_r) begin
          bundle.mask[BM_CR] = 1'b1;
          hcr_nxt = 1'b0;
        end
        if (b == CH_CR) begin
          hcr_nxt = 1'b1;
        end else if (!(!vstart_r && b == CH_SPACE)) begin
          bundle.mask[BM_BYTE] = 1'b1;
        end
        vstart_nxt = 1'b1;
      end
    end

    bundle.key   = akey_nxt;
    bundle.vbyte = b;

    // end of line: LF, NUL or packet end
    do_end = (phase_r != PH_DONE) && (term || item.packet_end);
    if (do_end) begin
      if (phase_r == PH_SEEK) begin
        if (pos_nxt != 4'd0) begin
          if (smis_nxt || pos_nxt != 4'(StatusLen)) begin
            pcls_nxt  = CLS_NO_HTTP;
            phase_nxt = PH_DONE;
          end else begin
            pcls_nxt  = CLS_UPNP;
            phase_nxt = PH_HDR;
          end
        end
      end else if (mode_nxt == MD_VAL) begin
        bundle.mask[BM_END] = 1'b1;
      end
      pos_nxt    = '0;
      mode_nxt   = MD_KEY;
      cand_nxt   = '1;
      akey_nxt   = '0;
      vstart_nxt = 1'b0;
      hcr_nxt    = 1'b0;
      smis_nxt   = 1'b0;
    end
    if (phase_r != PH_DONE && b == CH_NUL) phase_nxt = PH_DONE;

    if (item.packet_end) begin
      bundle.mask[BM_CLASS] = 1'b1;
      bundle.cls = pcls_nxt;
      phase_nxt  = PH_SEEK;
      pcls_nxt   = CLS_NONE;
      pos_nxt    = '0;
      mode_nxt   = MD_KEY;
      cand_nxt   = '1;
      akey_nxt   = '0;
      vstart_nxt = 1'b0;
      hcr_nxt    = 1'b0;
      smis_nxt   = 1'b0;
    end

    bundle_push = take && (bundle.mask != 4'd0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_SEEK;
      mode_r   <= MD_KEY;
      pos_r    <= '0;
      cand_r   <= '1;
      akey_r   <= '0;
      vstart_r <= 1'b0;
      hcr_r    <= 1'b0;
      smis_r   <= 1'b0;
      pcls_r   <= CLS_NONE;
    end else if (take) begin
      phase_r  <= phase_nxt;
      mode_r   <= mode_nxt;
      pos_r    <= pos_nxt;
      cand_r   <= cand_nxt;
      akey_r   <= akey_nxt;
      vstart_r <= vstart_nxt;
      hcr_r    <= hcr_nxt;
      smis_r   <= smis_nxt;
      pcls_r   <= pcls_nxt;
    end
  end

endmodule

@@ rtl/core/ssdp_queue.sv @@
// ssdp_queue: short bundle queue between the parser front and the result back end.
`timescale 1ns / 1ps
module ssdp_queue
  import ssdp_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    push,
  input  bundle_t push_data,
  input  logic    pop,
  output bundle_t head,
  output logic    full,
  output logic    empty
);

  bundle_t                entries_r [QueueDepth];
  logic [QueuePtrW-1:0]   wr_r, wr_nxt;
  logic [QueuePtrW-1:0]   rd_r, rd_nxt;
  logic [QueuePtrW:0]     cnt_r, cnt_nxt;
  logic                   do_push;
  logic                   do_pop;

  assign full    = (cnt_r == (QueuePtrW+1)'(QueueDepth));
  assign empty   = (cnt_r == '0);
  assign head    = entries_r[rd_r];
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  always_comb begin
    wr_nxt  = do_push ? wr_r + QueuePtrW'(1) : wr_r;
    rd_nxt  = do_pop ? rd_r + QueuePtrW'(1) : rd_r;
    cnt_nxt = cnt_r;
    if (do_push && !do_pop) cnt_nxt = cnt_r + (QueuePtrW+1)'(1);
    if (!do_push && do_pop) cnt_nxt = cnt_r - (QueuePtrW+1)'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) entries_r[wr_r] <= push_data;
  end

endmodule

@@ rtl/core/ssdp_back.sv @@
// ssdp_back: holds one bundle and hands out its results one per pop, oldest first.
`timescale 1ns / 1ps
module ssdp_back
  import ssdp_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  bundle_t   head,
  input  logic      q_empty,
  output logic      q_pop,
  input  logic      out_pop,
  output logic      out_empty,
  output out_item_t out_item
);

  logic [3:0] mask_r, mask_nxt;
  logic [3:0] key_r;
  logic [7:0] vbyte_r;
  logic [1:0] cls_r;
  logic [3:0] rest;
  logic       single;
  logic       load;

  assign out_empty = (mask_r == 4'd0);
  assign rest      = mask_r & (mask_r - 4'd1);
  assign single    = (rest == 4'd0);
  assign load      = (out_empty || (out_pop && single)) && !q_empty;
  assign q_pop     = load;

  always_comb begin
    out_item          = '0;
    out_item.run_last = single;
    if (mask_r[BM_CR]) begin
      out_item.result_kind = KIND_VALUE;
      out_item.header_key  = key_r;
      out_item.value_byte  = CH_CR;
    end else if (mask_r[BM_BYTE]) begin
      out_item.result_kind = KIND_VALUE;
      out_item.header_key  = key_r;
      out_item.value_byte  = vbyte_r;
    end else if (mask_r[BM_END]) begin
      out_item.result_kind = KIND_END;
      out_item.header_key  = key_r;
    end else begin
      out_item.result_kind    = KIND_CLASS;
      out_item.classification = cls_r;
    end

    mask_nxt = mask_r;
    if (load) begin
      mask_nxt = head.mask;
    end else if (out_pop && !out_empty) begin
      mask_nxt = rest;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mask_r <= '0;
    end else begin
      mask_r <= mask_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      key_r   <= head.key;
      vbyte_r <= head.vbyte;
      cls_r   <= head.cls;
    end
  end

endmodule

@@ rtl/core/ssdp_response_header_parser.sv @@
// ssdp_response_header_parser: top level of the SSDP response header parser.
// Results: an accepted byte's bundle is queued, then loaded into the back-end register.
// Throughput: one byte per cycle while in_full is low; a byte with k results holds the back
//   end for k pops; the 4-entry bundle queue absorbs bursts so in_full rises only when full.
// Reset: rst_n is synchronous, active low; parser goes to status-line search, queue empties.
`timescale 1ns / 1ps
module ssdp_response_header_parser
  import ssdp_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_push,
  output logic      in_full,
  input  in_item_t  in_item,
  output logic      out_empty,
  input  logic      out_pop,
  output out_item_t out_item
);

  logic    take;
  logic    bundle_push;
  bundle_t bundle;
  bundle_t head;
  logic    q_full;
  logic    q_empty;
  logic    q_pop;

  // an item is taken whenever the queue has room; bytes with no results push nothing
  assign in_full = q_full;
  assign take    = in_push && !q_full;

  // front: line splitting, status check, key match
  ssdp_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .take        (take),
    .item        (in_item),
    .bundle_push (bundle_push),
    .bundle      (bundle)
  );

  // decoupling queue of per-item result bundles
  ssdp_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (bundle_push),
    .push_data (bundle),
    .pop       (q_pop),
    .head      (head),
    .full      (q_full),
    .empty     (q_empty)
  );

  // back: serializes a bundle into single results
  ssdp_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head      (head),
    .q_empty   (q_empty),
    .q_pop     (q_pop),
    .out_pop   (out_pop),
    .out_empty (out_empty),
    .out_item  (out_item)
  );

endmodule
